### sv/assert_macros.svh
// Assertion macros shared by the page tag store RTL.
// No dependencies; expects clk and rst_n in the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Checked on every rising edge, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### sv/lpts_pkg.sv
// Package for the LRU page tag store: sizes, request modes, datapath ops,
// controller states and the command/status structs. No dependencies.
package lpts_pkg;

    localparam int ENTRIES  = 16;
    localparam int KEY_BITS = 32;
    localparam int SLOT_W   = $clog2(ENTRIES);
    localparam int RANK_W   = $clog2(ENTRIES);
    localparam int CNT_W    = $clog2(ENTRIES + 1);
    localparam int LIMIT_W  = 4;
    localparam int MODE_W   = 2;

    typedef enum logic [MODE_W-1:0] {
        MODE_GET    = 2'd0,
        MODE_FIND   = 2'd1,
        MODE_REMOVE = 2'd2,
        MODE_CLEAR  = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        OP_NOP,
        OP_LOOKUP,
        OP_PROMOTE,
        OP_EVICT,
        OP_ALLOC,
        OP_DROP,
        OP_FIND,
        OP_CLEAR
    } dp_op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_ACT,
        ST_ALLOC,
        ST_RESPOND
    } ctrl_state_t;

    typedef struct packed {
        logic   capture;   // latch request on input transfer
        dp_op_t op;
        logic   load_out;  // move result into output register
    } dp_cmd_t;

    typedef struct packed {
        mode_t mode;
        logic  hit;
        logic  evict_need;
    } dp_status_t;

    // index of lowest set bit, 0 if none
    function automatic logic [SLOT_W-1:0] low_index(input logic [ENTRIES-1:0] vec);
        logic [SLOT_W-1:0] idx;
        idx = '0;
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            if (vec[i])
            begin
                idx = SLOT_W'(i);
            end
        end
        return idx;
    endfunction

endpackage

### sv/lru_page_tag_store.sv
// Top level of the LRU page tag store: joins controller and datapath and
// packs the stream ports. Uses lpts_pkg, lpts_ctrl, lpts_dp.
//
//  channel  | handshake                | payload
//  ---------+--------------------------+---------------------------------------
//  request  | s_tvalid / s_tready      | s_tdata: mode, page_key
//  result   | m_tvalid / m_tready      | m_tdata: hit, slot, evicted,
//           |                          |          evicted_key, entry_count
//  config   | cfg_valid / cfg_ready    | cfg_data: cache_limit
//
// One request at a time: accept, lookup, update, respond. A request passes
// through the controller's steps (lookup, act, an allocate step after an
// eviction on a get miss, respond) over the single tag array.
// Reset clears valid bits, ranks and count and sets the limit to 15 at once; keys
// are not cleared. A result waiting on m_tready holds the store in its
// respond step; the output register frees the previous result meanwhile.
// cfg_ready is always high; write only while idle.
module lru_page_tag_store (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // [1:0] mode, [33:2] page_key, [39:34] zero
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // [0] hit, [4:1] slot, [5] evicted,
                                   // [37:6] evicted_key, [42:38] entry_count,
                                   // [47:43] zero
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [3:0]  cfg_data   // cache_limit
);
    import lpts_pkg::*;

    dp_cmd_t             cmd;
    dp_status_t          status;
    logic                res_hit;
    logic [SLOT_W-1:0]   res_slot;
    logic                res_evicted;
    logic [KEY_BITS-1:0] res_evicted_key;
    logic [CNT_W-1:0]    res_entry_count;

    assign cfg_ready = 1'b1;

    lpts_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .status    (status),
        .cmd       (cmd)
    );

    lpts_dp u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .status          (status),
        .in_mode         (mode_t'(s_tdata[1:0])),
        .in_key          (s_tdata[33:2]),
        .cfg_we          (cfg_valid && cfg_ready),
        .cfg_limit       (cfg_data),
        .out_hit         (res_hit),
        .out_slot        (res_slot),
        .out_evicted     (res_evicted),
        .out_evicted_key (res_evicted_key),
        .out_entry_count (res_entry_count)
    );

    assign m_tdata = {5'd0, res_entry_count, res_evicted_key, res_evicted,
                      res_slot, res_hit};

endmodule

### sv/lpts_dp.sv
// Datapath of the LRU page tag store: key array, valid bits, recency ranks,
// entry count, limit register and output register. Uses lpts_pkg.
module lpts_dp (
    input  logic                          clk,
    input  logic                          rst_n,
    input  lpts_pkg::dp_cmd_t             cmd,
    output lpts_pkg::dp_status_t          status,
    input  lpts_pkg::mode_t               in_mode,
    input  logic [lpts_pkg::KEY_BITS-1:0] in_key,
    input  logic                          cfg_we,
    input  logic [lpts_pkg::LIMIT_W-1:0]  cfg_limit,
    output logic                          out_hit,
    output logic [lpts_pkg::SLOT_W-1:0]   out_slot,
    output logic                          out_evicted,
    output logic [lpts_pkg::KEY_BITS-1:0] out_evicted_key,
    output logic [lpts_pkg::CNT_W-1:0]    out_entry_count
);
    import lpts_pkg::*;
    `include "assert_macros.svh"

    logic [KEY_BITS-1:0] key_mem [ENTRIES];
    logic [ENTRIES-1:0]  valid_reg, valid_next;
    logic [RANK_W-1:0]   rank_reg [ENTRIES];
    logic [RANK_W-1:0]   rank_next [ENTRIES];
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [LIMIT_W-1:0]  limit_reg;

    mode_t               mode_reg;
    logic [KEY_BITS-1:0] key_reg;
    logic                hit_reg, hit_next;
    logic [SLOT_W-1:0]   hit_slot_reg, hit_slot_next;
    logic [SLOT_W-1:0]   slot_res_reg, slot_res_next;
    logic                ev_reg, ev_next;
    logic [KEY_BITS-1:0] ev_key_reg, ev_key_next;

    logic                out_hit_reg;
    logic [SLOT_W-1:0]   out_slot_reg;
    logic                out_ev_reg;
    logic [KEY_BITS-1:0] out_ev_key_reg;
    logic [CNT_W-1:0]    out_count_reg;

    logic [ENTRIES-1:0]  match_vec, old_vec, free_vec;
    logic [SLOT_W-1:0]   old_slot, free_slot, drop_sel;
    logic                drop_en, key_we;
    logic [RANK_W-1:0]   ref_rank;

    always_comb
    begin
        for (int i = 0; i < ENTRIES; i++) begin
            match_vec[i] = valid_reg[i] && (key_mem[i] == key_reg);
            old_vec[i]   = valid_reg[i] &&
                           ((CNT_W'(rank_reg[i]) + CNT_W'(1)) == count_reg);
            free_vec[i]  = !valid_reg[i];
        end
    end

    assign old_slot  = low_index(old_vec);
    assign free_slot = low_index(free_vec);

    assign status.mode       = mode_reg;
    assign status.hit        = hit_reg;
    assign status.evict_need = (count_reg > CNT_W'(limit_reg)) ||
                               (count_reg >= CNT_W'(ENTRIES));

    always_comb
    begin
        valid_next    = valid_reg;
        rank_next     = rank_reg;
        count_next    = count_reg;
        hit_next      = hit_reg;
        hit_slot_next = hit_slot_reg;
        slot_res_next = slot_res_reg;
        ev_next       = ev_reg;
        ev_key_next   = ev_key_reg;
        drop_en       = 1'b0;
        drop_sel      = hit_slot_reg;
        key_we        = 1'b0;
        ref_rank      = rank_reg[hit_slot_reg];

        case (cmd.op)
            OP_LOOKUP:
            begin
                hit_next      = |match_vec;
                hit_slot_next = low_index(match_vec);
                slot_res_next = '0;
                ev_next       = 1'b0;
                ev_key_next   = '0;
            end
            OP_PROMOTE:
            begin
                // entries younger than the hit age by one, hit becomes newest
                for (int i = 0; i < ENTRIES; i++) begin
                    if (valid_reg[i] && (rank_reg[i] < ref_rank))
                    begin
                        rank_next[i] = rank_reg[i] + RANK_W'(1);
                    end
                end
                rank_next[hit_slot_reg] = '0;
                slot_res_next           = hit_slot_reg;
            end
            OP_EVICT:
            begin
                if (|old_vec)
                begin
                    ev_next     = 1'b1;
                    ev_key_next = key_mem[old_slot];
                    drop_en     = 1'b1;
                    drop_sel    = old_slot;
                end
            end
            OP_DROP:
            begin
                drop_en = 1'b1;
            end
            OP_ALLOC:
            begin
                if (|free_vec)
                begin
                    for (int i = 0; i < ENTRIES; i++) begin
                        if (valid_reg[i])
                        begin
                            rank_next[i] = rank_reg[i] + RANK_W'(1);
                        end
                    end
                    valid_next[free_slot] = 1'b1;
                    rank_next[free_slot]  = '0;
                    count_next            = count_reg + CNT_W'(1);
                    key_we                = 1'b1;
                    slot_res_next         = free_slot;
                end
            end
            OP_FIND:
            begin
                slot_res_next = hit_reg ? hit_slot_reg : '0;
            end
            OP_CLEAR:
            begin
                // clear reports no hit
                hit_next   = 1'b0;
                valid_next = '0;
                for (int i = 0; i < ENTRIES; i++) begin
                    rank_next[i] = '0;
                end
                count_next = '0;
            end
            default:
            begin
            end
        endcase

        if (drop_en)
        begin
            ref_rank = rank_reg[drop_sel];
            for (int i = 0; i < ENTRIES; i++) begin
                if (valid_reg[i] && (rank_reg[i] > ref_rank))
                begin
                    rank_next[i] = rank_reg[i] - RANK_W'(1);
                end
            end
            valid_next[drop_sel] = 1'b0;
            rank_next[drop_sel]  = '0;
            if (count_reg != '0)
            begin
                count_next = count_reg - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            count_reg <= '0;
            limit_reg <= LIMIT_W'(15);
            for (int i = 0; i < ENTRIES; i++) begin
                rank_reg[i] <= '0;
            end
        end
        else
        begin
            valid_reg <= valid_next;
            count_reg <= count_next;
            rank_reg  <= rank_next;
            if (cfg_we)
            begin
                limit_reg <= cfg_limit;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (key_we)
        begin
            key_mem[free_slot] <= key_reg;
        end
        if (cmd.capture)
        begin
            mode_reg <= in_mode;
            key_reg  <= in_key;
        end
        hit_reg      <= hit_next;
        hit_slot_reg <= hit_slot_next;
        slot_res_reg <= slot_res_next;
        ev_reg       <= ev_next;
        ev_key_reg   <= ev_key_next;
        if (cmd.load_out)
        begin
            out_hit_reg    <= hit_reg;
            out_slot_reg   <= slot_res_reg;
            out_ev_reg     <= ev_reg;
            out_ev_key_reg <= ev_key_reg;
            out_count_reg  <= count_reg;
        end
    end

    assign out_hit         = out_hit_reg;
    assign out_slot        = out_slot_reg;
    assign out_evicted     = out_ev_reg;
    assign out_evicted_key = out_ev_key_reg;
    assign out_entry_count = out_count_reg;

    `ASSERT_CLK(a_count_matches_valid, ($countones(valid_reg) == int'(count_reg)),
        "entry count differs from number of valid entries")
    `ASSERT_CLK(a_clear_empties, (cmd.op == OP_CLEAR) |=> (count_reg == '0 && valid_reg == '0),
        "clear left valid entries")

endmodule

### sv/lpts_ctrl.sv
// Controller of the LRU page tag store: sequences lookup, update and
// response for one request at a time. Uses lpts_pkg.
module lpts_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    input  lpts_pkg::dp_status_t status,
    output lpts_pkg::dp_cmd_t    cmd
);
    import lpts_pkg::*;
    `include "assert_macros.svh"

    ctrl_state_t state_reg, state_next;
    logic        out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        cmd.capture  = 1'b0;
        cmd.op       = OP_NOP;
        cmd.load_out = 1'b0;
        in_ready     = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_LOOKUP;
                end
            end
            ST_LOOKUP:
            begin
                cmd.op     = OP_LOOKUP;
                state_next = ST_ACT;
            end
            ST_ACT:
            begin
                state_next = ST_RESPOND;
                case (status.mode)
                    MODE_GET:
                    begin
                        if (status.hit)
                        begin
                            cmd.op = OP_PROMOTE;
                        end
                        else if (status.evict_need)
                        begin
                            cmd.op     = OP_EVICT;
                            state_next = ST_ALLOC;
                        end
                        else
                        begin
                            cmd.op = OP_ALLOC;
                        end
                    end
                    MODE_FIND:   cmd.op = OP_FIND;
                    MODE_REMOVE: cmd.op = status.hit ? OP_DROP : OP_NOP;
                    MODE_CLEAR:  cmd.op = OP_CLEAR;
                    default:     cmd.op = OP_NOP;
                endcase
            end
            ST_ALLOC:
            begin
                cmd.op     = OP_ALLOC;
                state_next = ST_RESPOND;
            end
            ST_RESPOND:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    assign out_valid = out_valid_reg;

    `ASSERT_CLK(a_accept_starts_lookup, (in_valid && in_ready) |=> (state_reg == ST_LOOKUP),
        "accepted request did not start a lookup")
    `ASSERT_CLK(a_alloc_after_evict, (state_reg == ST_ALLOC) |-> ($past(cmd.op) == OP_EVICT),
        "allocation step not preceded by eviction")

endmodule
